FILE: rtl/ifk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_pkg
// shared constants, register codes and types of the soft symbol demapper
// ----------------------------------------------------------------------------
package ifk_pkg;

    // tone set and default symbol width
    localparam int NUM_TONES        = 18;
    localparam int SYMBOL_BITS_DEF  = 10;

    // field and state widths
    localparam int N_W              = 7;   // paths * spacing, up to 15 * 7
    localparam int R_W              = N_W + 1;
    localparam int CONF_SHIFT       = 5;   // confidence in units of 1/32
    localparam int CONF_DIVIDEND_W  = N_W + CONF_SHIFT;
    localparam int CONF_W           = 6;
    localparam int DRIFT_W          = 6;
    localparam int MAG_W            = 7;
    localparam int SOFT_W           = 8;
    localparam int TWOS_W           = 4;
    localparam int RUN_W            = 8;

    // step limits and preamble markers
    localparam int STEP_MIN         = -16;
    localparam int STEP_MAX         = 17;
    localparam int STEP_TWO         = 2;
    localparam int DRIFT_LIMIT      = 31;
    localparam int TWOS_WRAP        = 14;

    localparam logic [SOFT_W-1:0] ERASURE   = 8'd128;
    localparam logic [SOFT_W-1:0] SOFT_MAX  = 8'd255;
    localparam logic [SOFT_W-1:0] SOFT_MIN  = 8'd0;
    localparam logic [SOFT_W-1:0] ZERO_BASE = 8'd127;
    localparam logic [MAG_W-1:0]  MAG_FULL  = 7'd127;
    localparam logic [CONF_W-1:0] CONF_ONE  = 6'd32;
    localparam logic [RUN_W-1:0]  RUN_SAT   = 8'd255;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATHS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd3;

    localparam logic [3:0] PATHS_RST   = 4'd4;
    localparam logic [2:0] SPACING_RST = 3'd1;

    // request to the shared divider
    typedef struct packed {
        logic           start;
        logic [N_W-1:0] divisor;
    } div_req_t;

    // per-symbol command handed to the demap state
    typedef struct packed {
        logic              commit;
        logic              burst;
        logic              squelch;
        logic              resync;
        logic              preamble_enable;
        logic [CONF_W-1:0] conf;
        logic [R_W-1:0]    drift;   // two's complement remainder
    } demap_cmd_t;

    // one result transaction
    typedef struct packed {
        logic [SOFT_W-1:0] soft_bit_0;
        logic [SOFT_W-1:0] soft_bit_1;
        logic [SOFT_W-1:0] soft_bit_2;
        logic [SOFT_W-1:0] soft_bit_3;
        logic              flush;
    } soft_result_t;

endpackage

FILE: rtl/ifk_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_ifs
// valid/ready channels for symbol transactions and soft bit transactions
// ----------------------------------------------------------------------------
interface ifk_sym_if #(
    parameter int SYMBOL_BITS = ifk_pkg::SYMBOL_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] symbol_index;
    logic                   static_burst;
    logic                   squelched;

    modport source (output valid, output symbol_index, output static_burst,
                    output squelched, input ready);
    modport sink   (input valid, input symbol_index, input static_burst,
                    input squelched, output ready);
endinterface

interface ifk_soft_if;
    logic                          valid;
    logic                          ready;
    logic [ifk_pkg::SOFT_W-1:0]    soft_bit_0;
    logic [ifk_pkg::SOFT_W-1:0]    soft_bit_1;
    logic [ifk_pkg::SOFT_W-1:0]    soft_bit_2;
    logic [ifk_pkg::SOFT_W-1:0]    soft_bit_3;
    logic                          flush;

    modport source (output valid, output soft_bit_0, output soft_bit_1,
                    output soft_bit_2, output soft_bit_3, output flush, input ready);
    modport sink   (input valid, input soft_bit_0, input soft_bit_1,
                    input soft_bit_2, input soft_bit_3, input flush, output ready);
endinterface

FILE: rtl/ifk_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ifk_div #(
    parameter int DIV_W = ifk_pkg::CONF_DIVIDEND_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ifk_pkg::div_req_t         req,
    input  logic [DIV_W-1:0]          dividend,
    output logic [DIV_W-1:0]          quotient,
    output logic [ifk_pkg::N_W-1:0]   remainder,
    output logic                      done
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]        quo_reg, quo_next;
    logic [ifk_pkg::N_W-1:0] rem_reg, rem_next;
    logic [ifk_pkg::N_W-1:0] dvs_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [ifk_pkg::N_W:0]   trial;
    logic                    fits;

    // shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? ifk_pkg::N_W'(trial - {1'b0, dvs_reg}) : trial[ifk_pkg::N_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: rtl/ifk_demap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_demap
// demapper state, preamble detector and soft byte weighting
// ----------------------------------------------------------------------------
module ifk_demap #(
    parameter int SYMBOL_BITS = ifk_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ifk_pkg::demap_cmd_t             cmd,
    input  logic [SYMBOL_BITS-1:0]          cur,
    input  logic signed [SYMBOL_BITS+1:0]   step,
    output ifk_pkg::soft_result_t           result,
    output logic [SYMBOL_BITS-1:0]          prev_symbol,
    output logic [ifk_pkg::DRIFT_W-1:0]     prev_drift
);
    localparam int CW = SYMBOL_BITS + 2;

    logic [SYMBOL_BITS-1:0]          prev_symbol_reg;
    logic [3:0]                      held_nibble_reg;
    logic [ifk_pkg::MAG_W-1:0]       held_mag_reg;
    logic [ifk_pkg::MAG_W-1:0]       pend_mag_reg;
    logic [ifk_pkg::DRIFT_W-1:0]     prev_drift_reg;
    logic [ifk_pkg::CONF_W-1:0]      held_conf_reg;
    logic [ifk_pkg::TWOS_W-1:0]      twos_reg, twos_next;
    logic                            m16_reg, m16_next;
    logic [ifk_pkg::RUN_W-1:0]       run_reg, run_next;

    logic                            is_m16, is_two, out_of_range, fire, hit;
    logic [ifk_pkg::TWOS_W-1:0]      tc0, tc1;
    logic signed [CW-1:0]            nib_full;
    logic [3:0]                      nib;
    logic [ifk_pkg::MAG_W-1:0]       last_mag, now_mag, next_mag;
    logic [ifk_pkg::CONF_W-1:0]      conf_eff;
    logic [ifk_pkg::MAG_W+ifk_pkg::CONF_W-1:0] prod;
    logic [ifk_pkg::SOFT_W-1:0]      weighted, one_val, zero_val;
    logic signed [ifk_pkg::R_W-1:0]  drift_in, drift_sat;

    // preamble detector: counts +2 steps and looks for a -16 step
    always_comb
    begin
        is_m16 = (step == ifk_pkg::STEP_MIN);
        is_two = (step == ifk_pkg::STEP_TWO);
        tc0    = (twos_reg > ifk_pkg::TWOS_W'(ifk_pkg::TWOS_WRAP)) ? '0 : twos_reg;
        tc1    = tc0;
        m16_next = m16_reg;
        if (is_m16 && (tc0 > ifk_pkg::TWOS_W'(2)))
        begin
            m16_next = 1'b1;
        end
        else if (!is_two)
        begin
            m16_next = 1'b0;
        end
        else
        begin
            tc1 = tc0 + 1'b1;
        end
        twos_next = tc1;
        if (!is_m16 && !is_two && (tc1 > ifk_pkg::TWOS_W'(1)))
        begin
            twos_next = tc1 - ifk_pkg::TWOS_W'(2);
        end
        hit = (twos_next > ifk_pkg::TWOS_W'(4)) && m16_next;
        if (hit)
        begin
            run_next = (run_reg == ifk_pkg::RUN_SAT) ? run_reg : run_reg + 1'b1;
        end
        else
        begin
            run_next = '0;
        end
        fire = cmd.preamble_enable && hit && (run_next > ifk_pkg::RUN_W'(4));
    end

    // nibble, magnitudes and weighting
    always_comb
    begin
        out_of_range = (step < ifk_pkg::STEP_MIN) || (step == 0) || (step == 1) ||
                       (step > ifk_pkg::STEP_MAX);
        nib_full = (step < ifk_pkg::STEP_TWO) ?
                   step + CW'(ifk_pkg::NUM_TONES - ifk_pkg::STEP_TWO) :
                   step - CW'(ifk_pkg::STEP_TWO);
        nib      = nib_full[3:0];

        last_mag = held_mag_reg;
        now_mag  = pend_mag_reg;
        next_mag = ifk_pkg::MAG_FULL;
        if (out_of_range)
        begin
            last_mag = held_mag_reg >> 1;
            now_mag  = '0;
            next_mag = ifk_pkg::MAG_FULL >> 1;
        end
        if (cur == '0)
        begin
            now_mag  = '0;
            next_mag = '0;
        end
        if (cmd.squelch)
        begin
            now_mag = '0;
        end
        if (cmd.burst)
        begin
            now_mag  = now_mag >> 4;
            next_mag = next_mag >> 4;
        end

        conf_eff = cmd.resync ? ifk_pkg::CONF_ONE : held_conf_reg;
        prod     = {{ifk_pkg::CONF_W{1'b0}}, last_mag} *
                   {{ifk_pkg::MAG_W{1'b0}}, conf_eff};
        weighted = prod[ifk_pkg::CONF_SHIFT +: ifk_pkg::SOFT_W];

        priority if (weighted == '0)
        begin
            one_val  = ifk_pkg::ERASURE;
            zero_val = ifk_pkg::ERASURE;
        end
        else if (weighted > ifk_pkg::SOFT_W'(ifk_pkg::ZERO_BASE))
        begin
            one_val  = ifk_pkg::SOFT_MAX;
            zero_val = ifk_pkg::SOFT_MIN;
        end
        else
        begin
            one_val  = ifk_pkg::ERASURE + weighted;
            zero_val = ifk_pkg::ZERO_BASE - weighted;
        end

        drift_in = $signed(cmd.drift);
        priority if (drift_in > ifk_pkg::DRIFT_LIMIT)
        begin
            drift_sat = ifk_pkg::R_W'(ifk_pkg::DRIFT_LIMIT);
        end
        else if (drift_in < -ifk_pkg::DRIFT_LIMIT)
        begin
            drift_sat = ifk_pkg::R_W'(-ifk_pkg::DRIFT_LIMIT);
        end
        else
        begin
            drift_sat = drift_in;
        end

        if (fire)
        begin
            result.soft_bit_0 = ifk_pkg::ERASURE;
            result.soft_bit_1 = ifk_pkg::ERASURE;
            result.soft_bit_2 = ifk_pkg::ERASURE;
            result.soft_bit_3 = ifk_pkg::ERASURE;
            result.flush      = 1'b1;
        end
        else
        begin
            result.soft_bit_0 = held_nibble_reg[3] ? one_val : zero_val;
            result.soft_bit_1 = held_nibble_reg[2] ? one_val : zero_val;
            result.soft_bit_2 = held_nibble_reg[1] ? one_val : zero_val;
            result.soft_bit_3 = held_nibble_reg[0] ? one_val : zero_val;
            result.flush      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_symbol_reg <= '0;
            held_nibble_reg <= '0;
            held_mag_reg    <= '0;
            pend_mag_reg    <= '0;
            prev_drift_reg  <= '0;
            held_conf_reg   <= '0;
            twos_reg        <= '0;
            m16_reg         <= 1'b0;
            run_reg         <= '0;
        end
        else if (cmd.commit)
        begin
            prev_symbol_reg <= cur;
            if (cmd.preamble_enable)
            begin
                twos_reg <= twos_next;
                m16_reg  <= m16_next;
                run_reg  <= run_next;
            end
            if (fire)
            begin
                held_mag_reg <= '0;
            end
            else
            begin
                held_nibble_reg <= nib;
                held_mag_reg    <= now_mag;
                pend_mag_reg    <= next_mag;
                held_conf_reg   <= cmd.conf;
                prev_drift_reg  <= drift_sat[ifk_pkg::DRIFT_W-1:0];
            end
        end
    end

    assign prev_symbol = prev_symbol_reg;
    assign prev_drift  = prev_drift_reg;

endmodule

FILE: rtl/ifk_soft_symbol_demapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_soft_symbol_demapper_top
// soft symbol demapper for differential incremental frequency keying
// ----------------------------------------------------------------------------
// usage
//   sym_in carries one transaction per symbol period: the detected bin index
//   plus the static burst and squelch flags. soft_out carries one transaction
//   per symbol: four soft bytes for the nibble of the previous symbol, or a
//   flush marker when the preamble detector fires.
//   cfg_we / cfg_index / cfg_wdata write paths, spacing_factor, reverse and
//   preamble_enable; write only while the block is idle.
// timing
//   one shared restoring divider (DIV_W = max(SYMBOL_BITS, 12) bits, one
//   quotient bit per cycle) runs twice per symbol: tone step and drift
//   remainder first, then the drift confidence. soft_out.valid rises once an
//   accepted symbol is done, and sym_in.ready rises in the same cycle.
//   sym_in.ready is low while a symbol is being worked on.
// reset and stall
//   rst_n clears all demapper state to zero and loads the register defaults
//   (paths 4, spacing 1, reverse 0, preamble on). the result sits in an
//   output register; a new symbol is accepted while it waits, and that
//   symbol holds in its final step until soft_out is free again.
// ----------------------------------------------------------------------------
module ifk_soft_symbol_demapper_top #(
    parameter int SYMBOL_BITS = ifk_pkg::SYMBOL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ifk_sym_if.sink                             sym_in,
    ifk_soft_if.source                          soft_out,
    input  logic                                cfg_we,
    input  logic [ifk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ifk_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    localparam int CW    = SYMBOL_BITS + 2;
    localparam int DIV_W = (SYMBOL_BITS > ifk_pkg::CONF_DIVIDEND_W) ?
                           SYMBOL_BITS : ifk_pkg::CONF_DIVIDEND_W;
    localparam int NW    = ifk_pkg::N_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_QUO    = 3'd2;
    localparam logic [2:0] ST_CONF   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [3:0] paths_reg;
    logic [2:0] spacing_reg;
    logic       reverse_reg;
    logic       preamble_reg;

    // symbol under work
    logic [SYMBOL_BITS-1:0]           cur_reg;
    logic                             burst_reg;
    logic                             squelch_reg;
    logic [NW-1:0]                    n_reg;
    logic                             draw_neg_reg;
    logic signed [CW-1:0]             step_reg;
    logic [ifk_pkg::R_W-1:0]          drift_reg;
    logic                             resync_reg;
    logic [ifk_pkg::CONF_W-1:0]       conf_reg;

    // output register
    logic                             out_valid_reg;
    ifk_pkg::soft_result_t            out_reg;

    // divider hookup
    ifk_pkg::div_req_t                div_req;
    logic [DIV_W-1:0]                 div_dividend;
    logic [DIV_W-1:0]                 div_quotient;
    logic [NW-1:0]                    div_remainder;
    logic                             div_done;

    // demap hookup
    ifk_pkg::demap_cmd_t              dm_cmd;
    ifk_pkg::soft_result_t            dm_result;
    logic [SYMBOL_BITS-1:0]           prev_symbol;
    logic [ifk_pkg::DRIFT_W-1:0]      prev_drift;

    // combinational helpers
    logic                             in_fire;
    logic                             out_free;
    logic                             commit;
    logic [3:0]                       p_eff;
    logic [2:0]                       s_eff;
    logic [NW-1:0]                    n_comb;
    logic [SYMBOL_BITS:0]             draw_diff, draw_negated;
    logic [SYMBOL_BITS-1:0]           draw_abs;
    logic [SYMBOL_BITS-1:0]           q_sb;
    logic [NW:0]                      rm_twice;
    logic                             round_pos, round_neg, d_neg;
    logic [CW-1:0]                    step_mag;
    logic signed [CW-1:0]             step_comb;
    logic signed [ifk_pkg::R_W-1:0]   r_signed, pd_neg;
    logic                             resync_comb;
    logic [NW-1:0]                    ar, x_val;

    assign in_fire  = sym_in.valid && sym_in.ready;
    assign out_free = !out_valid_reg || soft_out.ready;
    assign commit   = (state_reg == ST_FINISH) && out_free;

    // a zero in paths or spacing counts as one
    assign p_eff  = (paths_reg == '0) ? 4'd1 : paths_reg;
    assign s_eff  = (spacing_reg == '0) ? 3'd1 : spacing_reg;
    assign n_comb = {3'b000, p_eff} * {4'b0000, s_eff};

    // bin step against the previous symbol, split into sign and size
    assign draw_diff    = {1'b0, cur_reg} - {1'b0, prev_symbol};
    assign draw_negated = -draw_diff;
    assign draw_abs     = draw_diff[SYMBOL_BITS] ? draw_negated[SYMBOL_BITS-1:0] :
                                                  draw_diff[SYMBOL_BITS-1:0];

    // rounded tone step and truncated remainder from |step| / n
    always_comb
    begin
        q_sb      = div_quotient[SYMBOL_BITS-1:0];
        rm_twice  = {div_remainder, 1'b0};
        round_pos = (rm_twice >= {1'b0, n_reg});
        round_neg = (rm_twice > {1'b0, n_reg});
        d_neg     = draw_neg_reg ^ reverse_reg;
        if (d_neg)
        begin
            step_mag  = CW'(q_sb) + CW'(round_neg);
            step_comb = -$signed(step_mag);
        end
        else
        begin
            step_mag  = CW'(q_sb) + CW'(round_pos);
            step_comb = $signed(step_mag);
        end

        r_signed = draw_neg_reg ? -$signed({1'b0, div_remainder}) :
                                  $signed({1'b0, div_remainder});
        pd_neg   = -$signed({{(ifk_pkg::R_W - ifk_pkg::DRIFT_W){prev_drift[ifk_pkg::DRIFT_W-1]}},
                            prev_drift});
        // drift that undoes the previous one is a resync
        resync_comb = (div_remainder != '0) && (pd_neg == r_signed);
        ar    = resync_comb ? '0 : div_remainder;
        x_val = (ar <= (n_reg >> 1)) ? (n_reg - ar) : ar;
    end

    // divider requests: |step| / n, then 32 * x / n
    always_comb
    begin
        div_req.start   = 1'b0;
        div_req.divisor = n_reg;
        div_dividend    = DIV_W'(draw_abs);
        if (state_reg == ST_SETUP)
        begin
            div_req.start   = 1'b1;
            div_req.divisor = n_comb;
        end
        else if ((state_reg == ST_QUO) && div_done)
        begin
            div_req.start = 1'b1;
            div_dividend  = DIV_W'({x_val, {ifk_pkg::CONF_SHIFT{1'b0}}});
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_QUO;
            ST_QUO:    if (div_done) state_next = ST_CONF;
            ST_CONF:   if (div_done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            paths_reg     <= ifk_pkg::PATHS_RST;
            spacing_reg   <= ifk_pkg::SPACING_RST;
            reverse_reg   <= 1'b0;
            preamble_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (soft_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ifk_pkg::CFG_PATHS:    paths_reg    <= cfg_wdata[3:0];
                    ifk_pkg::CFG_SPACING:  spacing_reg  <= cfg_wdata[2:0];
                    ifk_pkg::CFG_REVERSE:  reverse_reg  <= cfg_wdata[0];
                    ifk_pkg::CFG_PREAMBLE: preamble_reg <= cfg_wdata[0];
                    default:               paths_reg    <= paths_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg     <= sym_in.symbol_index;
            burst_reg   <= sym_in.static_burst;
            squelch_reg <= sym_in.squelched;
        end
        if (state_reg == ST_SETUP)
        begin
            n_reg        <= n_comb;
            draw_neg_reg <= draw_diff[SYMBOL_BITS];
        end
        if ((state_reg == ST_QUO) && div_done)
        begin
            step_reg   <= step_comb;
            drift_reg  <= resync_comb ? '0 : r_signed;
            resync_reg <= resync_comb;
        end
        if ((state_reg == ST_CONF) && div_done)
        begin
            conf_reg <= div_quotient[ifk_pkg::CONF_W-1:0];
        end
        if (commit)
        begin
            out_reg <= dm_result;
        end
    end

    assign dm_cmd.commit          = commit;
    assign dm_cmd.burst           = burst_reg;
    assign dm_cmd.squelch         = squelch_reg;
    assign dm_cmd.resync          = resync_reg;
    assign dm_cmd.preamble_enable = preamble_reg;
    assign dm_cmd.conf            = conf_reg;
    assign dm_cmd.drift           = drift_reg;

    ifk_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .done      (div_done)
    );

    ifk_demap #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_demap (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dm_cmd),
        .cur         (cur_reg),
        .step        (step_reg),
        .result      (dm_result),
        .prev_symbol (prev_symbol),
        .prev_drift  (prev_drift)
    );

    // channel outputs
    assign sym_in.ready        = (state_reg == ST_IDLE);
    assign soft_out.valid      = out_valid_reg;
    assign soft_out.soft_bit_0 = out_reg.soft_bit_0;
    assign soft_out.soft_bit_1 = out_reg.soft_bit_1;
    assign soft_out.soft_bit_2 = out_reg.soft_bit_2;
    assign soft_out.soft_bit_3 = out_reg.soft_bit_3;
    assign soft_out.flush      = out_reg.flush;

    // checks
    a_one_symbol_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !sym_in.ready)
        else $error("new symbol taken while one is in work");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_QUO || state_reg == ST_CONF))
        else $error("divider finished outside a wait state");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONF && div_done) |-> (div_quotient <= DIV_W'(32)))
        else $error("confidence above one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !soft_out.ready)
        |=> (state_reg == ST_FINISH && out_valid_reg))
        else $error("result lost while receiver stalls");

    a_flush_erasure: assert property (@(posedge clk) disable iff (!rst_n)
        (soft_out.valid && soft_out.flush) |->
        (soft_out.soft_bit_0 == ifk_pkg::ERASURE && soft_out.soft_bit_3 == ifk_pkg::ERASURE))
        else $error("flush transaction with non-erasure soft bits");

endmodule

FILE: tb/ifk_demap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifk_demap_checker
// Watches the symbol, soft bit and register ports of the demapper. For every
// accepted symbol it predicts the soft bit transaction, or the flush marker,
// and checks each soft bit transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module ifk_demap_checker #(
    parameter int SYMBOL_BITS = ifk_pkg::SYMBOL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ifk_sym_if                             sym,
    ifk_soft_if                            soft_ch,
    input  logic                           cfg_we,
    input  logic [ifk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ifk_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import ifk_pkg::*;

    // register copy
    logic [3:0]                cfg_paths;
    logic [2:0]                cfg_spacing;
    logic                      cfg_reverse;
    logic                      cfg_preamble;

    // demapper state copy
    logic [SYMBOL_BITS-1:0]    prev_symbol;
    logic [3:0]                held_nib;
    logic [MAG_W-1:0]          held_mag;
    logic [MAG_W-1:0]          pend_mag;
    logic signed [DRIFT_W-1:0] last_drift;
    logic [CONF_W-1:0]         held_conf;
    logic [TWOS_W-1:0]         twos;
    logic                      saw_minus16;
    logic [RUN_W-1:0]          run_len;

    soft_result_t expected_soft_q[$];
    int           fail_total;

    assign mismatches = fail_total;

    // soft bit transaction caused by one symbol; advances the state copy
    function automatic soft_result_t demap_symbol(input int cur, input bit burst,
                                                  input bit squelch);
        soft_result_t res;
        int  n, draw, d, num, den, c, r, ar, nowconf, lastmag, nowmag, nextmag, nib;
        bit  outofrange, flush_now;
        logic [SOFT_W-1:0] one_val, zero_val;
        n = (cfg_paths == 0 ? 1 : int'(cfg_paths)) *
            (cfg_spacing == 0 ? 1 : int'(cfg_spacing));
        draw = cur - int'(prev_symbol);
        d = cfg_reverse ? -draw : draw;
        num = 2 * d + n;
        den = 2 * n;
        c = num / den;
        if (num % den != 0 && num < 0)
        begin
            c = c - 1;
        end
        outofrange = (c < STEP_MIN) || (c == 0) || (c == 1) || (c > STEP_MAX);

        // preamble detector: twos, a minus sixteen, then a run of twos
        flush_now = 1'b0;
        if (cfg_preamble)
        begin
            if (twos > TWOS_WRAP)
            begin
                twos = '0;
            end
            if (c == STEP_MIN && twos > 2)
            begin
                saw_minus16 = 1'b1;
            end
            else if (c != STEP_TWO)
            begin
                saw_minus16 = 1'b0;
            end
            else
            begin
                twos = twos + 1'b1;
            end
            if (c != STEP_MIN && c != STEP_TWO && twos > 1)
            begin
                twos = twos - 2'd2;
            end
            if (twos > 4 && saw_minus16)
            begin
                if (run_len < RUN_SAT)
                begin
                    run_len = run_len + 1'b1;
                end
                flush_now = (run_len > 4);
            end
            else
            begin
                run_len = '0;
            end
        end
        if (flush_now)
        begin
            held_mag = '0;
            prev_symbol = SYMBOL_BITS'(cur);
            res = '{ERASURE, ERASURE, ERASURE, ERASURE, 1'b1};
            return res;
        end

        nib = c - 2;
        if (nib < 0)
        begin
            nib = nib + NUM_TONES;
        end

        // drift remainder and its confidence
        r = draw % n;
        if (r == 0)
        begin
            nowconf = int'(CONF_ONE);
        end
        else
        begin
            if (r == -int'(last_drift))
            begin
                r = 0;
                held_conf = CONF_ONE;
            end
            ar = (r < 0) ? -r : r;
            if (ar <= n / 2)
            begin
                nowconf = (int'(CONF_ONE) * (n - ar)) / n;
            end
            else
            begin
                nowconf = (int'(CONF_ONE) * ar) / n;
            end
        end
        if (r > DRIFT_LIMIT)
        begin
            r = DRIFT_LIMIT;
        end
        if (r < -DRIFT_LIMIT)
        begin
            r = -DRIFT_LIMIT;
        end
        last_drift = DRIFT_W'(r);

        lastmag = int'(held_mag);
        nowmag  = int'(pend_mag);
        nextmag = int'(MAG_FULL);
        if (outofrange)
        begin
            lastmag = lastmag / 2;
            nowmag  = 0;
            nextmag = nextmag / 2;
        end
        if (cur == 0)
        begin
            nowmag  = 0;
            nextmag = 0;
        end
        if (squelch)
        begin
            nowmag = 0;
        end
        if (burst)
        begin
            nowmag  = nowmag / 16;
            nextmag = nextmag / 16;
        end
        lastmag = (lastmag * int'(held_conf)) / (1 << CONF_SHIFT);

        if (lastmag <= 0)
        begin
            one_val  = ERASURE;
            zero_val = ERASURE;
        end
        else if (lastmag > int'(ZERO_BASE))
        begin
            one_val  = SOFT_MAX;
            zero_val = SOFT_MIN;
        end
        else
        begin
            one_val  = ERASURE + SOFT_W'(lastmag);
            zero_val = ZERO_BASE - SOFT_W'(lastmag);
        end
        res.soft_bit_0 = held_nib[3] ? one_val : zero_val;
        res.soft_bit_1 = held_nib[2] ? one_val : zero_val;
        res.soft_bit_2 = held_nib[1] ? one_val : zero_val;
        res.soft_bit_3 = held_nib[0] ? one_val : zero_val;
        res.flush      = 1'b0;

        held_nib    = 4'(nib);
        held_mag    = MAG_W'(nowmag);
        pend_mag    = MAG_W'(nextmag);
        held_conf   = CONF_W'(nowconf);
        prev_symbol = SYMBOL_BITS'(cur);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        soft_result_t want;
        soft_result_t got;
        if (!rst_n)
        begin
            cfg_paths    = PATHS_RST;
            cfg_spacing  = SPACING_RST;
            cfg_reverse  = 1'b0;
            cfg_preamble = 1'b1;
            prev_symbol  = '0;
            held_nib     = '0;
            held_mag     = '0;
            pend_mag     = '0;
            last_drift   = '0;
            held_conf    = '0;
            twos         = '0;
            saw_minus16  = 1'b0;
            run_len      = '0;
            fail_total   = 0;
            expected_soft_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first, so a result with nothing waiting is caught
            if (soft_ch.valid && soft_ch.ready)
            begin
                got.soft_bit_0 = soft_ch.soft_bit_0;
                got.soft_bit_1 = soft_ch.soft_bit_1;
                got.soft_bit_2 = soft_ch.soft_bit_2;
                got.soft_bit_3 = soft_ch.soft_bit_3;
                got.flush      = soft_ch.flush;
                if (expected_soft_q.size() == 0)
                begin
                    if (fail_total < 10)
                    begin
                        $display({"%0t: soft transaction with none expected: ",
                                  "%0d %0d %0d %0d flush %0b"},
                                 $time, got.soft_bit_0, got.soft_bit_1, got.soft_bit_2,
                                 got.soft_bit_3, got.flush);
                    end
                    fail_total++;
                end
                else
                begin
                    want = expected_soft_q.pop_front();
                    if (got.soft_bit_0 !== want.soft_bit_0 ||
                        got.soft_bit_1 !== want.soft_bit_1 ||
                        got.soft_bit_2 !== want.soft_bit_2 ||
                        got.soft_bit_3 !== want.soft_bit_3 ||
                        got.flush !== want.flush)
                    begin
                        if (fail_total < 10)
                        begin
                            $display({"%0t: soft mismatch, expected %0d %0d %0d %0d flush %0b, ",
                                      "got %0d %0d %0d %0d flush %0b"},
                                     $time, want.soft_bit_0, want.soft_bit_1,
                                     want.soft_bit_2, want.soft_bit_3, want.flush,
                                     got.soft_bit_0, got.soft_bit_1, got.soft_bit_2,
                                     got.soft_bit_3, got.flush);
                        end
                        fail_total++;
                    end
                end
            end
            if (sym.valid && sym.ready)
            begin
                expected_soft_q.push_back(demap_symbol(int'(sym.symbol_index),
                                                       sym.static_burst, sym.squelched));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATHS:    cfg_paths    = cfg_wdata[3:0];
                    CFG_SPACING:  cfg_spacing  = cfg_wdata[2:0];
                    CFG_REVERSE:  cfg_reverse  = cfg_wdata[0];
                    CFG_PREAMBLE: cfg_preamble = cfg_wdata[0];
                    default:      ;
                endcase
            end
            outstanding <= expected_soft_q.size();
        end
    end

endmodule

FILE: tb/tb_ifk_soft_symbol_demapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ifk_soft_symbol_demapper_top
// Drives symbol transactions into the soft symbol demapper under a series of
// register settings and lets a checker predict and compare every soft bit
// transaction. Stimulus is a directed opening, then mostly well-formed tone
// steps, preamble sequences, out-of-range steps and raw noise, with random
// idling on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_ifk_soft_symbol_demapper_top;
    import ifk_pkg::*;

    localparam int SYM_W      = SYMBOL_BITS_DEF;
    localparam int SYM_MAX    = (1 << SYM_W) - 1;
    localparam int PHASE_LEN  = 120;      // symbols per register setting
    localparam int NUM_FIXED  = 10;
    localparam int NUM_PHASES = 14;
    localparam int HOLD_LEN   = 300;      // long receiver hold-off in cycles
    localparam int CYCLE_MAX  = 400000;   // watchdog

    // fixed register settings: paths, spacing, reverse, preamble enable
    localparam int PHASE_SET [NUM_FIXED][4] = '{
        '{1, 1, 0, 1},      // smallest step size
        '{8, 4, 1, 1},      // largest nominal step size, reversed
        '{0, 0, 0, 0},      // zero registers count as one, detector off
        '{15, 7, 1, 1},     // widest step, drift saturates
        '{2, 3, 0, 1},
        '{3, 2, 1, 0},
        '{4, 1, 0, 1},      // back to the reset values
        '{8, 1, 1, 1},
        '{4, 4, 0, 1},
        '{6, 5, 0, 1}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending_results;
    int cycle_count = 0;

    // stimulus side view of the block, only used to aim tone steps
    int       stim_n = 4;
    bit       stim_reverse = 1'b0;
    int       last_symbol = 0;
    int       items_sent = 0;
    bit       send_steady = 1'b0;

    ifk_sym_if  #(.SYMBOL_BITS(SYM_W)) sym_if ();
    ifk_soft_if                        soft_if ();

    ifk_soft_symbol_demapper_top #(
        .SYMBOL_BITS (SYM_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_in    (sym_if),
        .soft_out  (soft_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ifk_demap_checker #(
        .SYMBOL_BITS (SYM_W)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym         (sym_if),
        .soft_ch     (soft_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .outstanding (pending_results)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one symbol transaction: random gap, then hold valid until accepted.
    // called in the time step of the previous acceptance, so valid is only
    // lowered when a gap follows and never lowered and raised in one step
    task automatic send_symbol(input logic [SYM_W-1:0] value, input bit burst,
                               input bit squelch);
        int gap;
        // every 40 symbols decide whether the next stretch runs without gaps
        if (items_sent % 40 == 0)
        begin
            send_steady = ($urandom_range(0, 3) == 0);
        end
        gap = send_steady ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_if.valid        <= 1'b1;
        sym_if.symbol_index <= value;
        sym_if.static_burst <= burst;
        sym_if.squelched    <= squelch;
        do @(posedge clk); while (!sym_if.ready);
        last_symbol = int'(value);
        items_sent++;
    endtask

    // aim the next symbol so that it makes tone step c with the given drift;
    // if that leaves the bin range, step the other way, else fall back to noise
    task automatic send_step(input int c, input int drift, input bit burst,
                             input bit squelch);
        int d;
        int target;
        d = c * stim_n + drift;
        if (stim_reverse)
        begin
            d = -d;
        end
        target = last_symbol + d;
        if (target < 0 || target > SYM_MAX)
        begin
            target = last_symbol - d;
        end
        if (target < 0 || target > SYM_MAX)
        begin
            target = int'($urandom_range(1, SYM_MAX));
        end
        send_symbol(SYM_W'(target), burst, squelch);
    endtask

    // random traffic for one register setting
    task automatic run_traffic(input int count);
        int stop, kind, c, drift, mag, v, lead, tail;
        bit burst, squelch;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            kind    = $urandom_range(0, 19);
            burst   = ($urandom_range(0, 9) == 0);
            squelch = ($urandom_range(0, 9) == 0);
            if (kind < 14)
            begin
                // well-formed tone step: -16..-1 or 2..17 with some drift
                v = $urandom_range(0, 31);
                c = (v < 16) ? v + STEP_MIN : v - 14;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: drift = 0;
                    5, 6, 7:
                    begin
                        mag = $urandom_range(1, 2);
                        drift = (mag > stim_n / 2) ? 0 : mag;
                        if ($urandom_range(0, 1) == 1)
                        begin
                            drift = -drift;
                        end
                    end
                    default: drift = int'($urandom_range(0, 2 * stim_n - 2)) - (stim_n - 1);
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    send_symbol('0, burst, squelch);        // puncture
                end
                else
                begin
                    send_step(c, drift, burst, squelch);
                end
            end
            else if (kind < 16)
            begin
                // preamble: twos, one minus sixteen, then a run of twos
                lead = $urandom_range(2, 8);
                tail = $urandom_range(3, 14);
                repeat (lead) send_step(STEP_TWO, 0, 1'b0, 1'b0);
                send_step(STEP_MIN, 0, 1'b0, 1'b0);
                repeat (tail) send_step(STEP_TWO, 0, 1'b0, 1'b0);
            end
            else if (kind < 18)
            begin
                // steps outside the tone set
                case ($urandom_range(0, 3))
                    0:       c = 0;
                    1:       c = 1;
                    2:       c = $urandom_range(STEP_MAX + 1, STEP_MAX + 7);
                    default: c = STEP_MIN - int'($urandom_range(1, 8));
                endcase
                send_step(c, 0, burst, squelch);
            end
            else
            begin
                send_symbol(SYM_W'($urandom_range(0, SYM_MAX)), burst, squelch);
            end
        end
    endtask

    // receiver: random stall per transaction, long hold-offs twice
    initial
    begin : receiver
        int stall;
        int results_seen;
        bit recv_steady;
        results_seen = 0;
        recv_steady  = 1'b0;
        soft_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 40 == 0)
            begin
                recv_steady = ($urandom_range(0, 3) == 0);
            end
            stall = recv_steady ? 0 : int'($urandom_range(0, 5));
            // hold off long enough for the block to fill and stall its input
            if (results_seen == 250 || results_seen == 1000)
            begin
                stall = HOLD_LEN;
            end
            if (stall > 0)
            begin
                soft_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            soft_if.ready <= 1'b1;
            do @(posedge clk); while (!soft_if.valid);
            results_seen++;
        end
    end

    // main sequence
    initial
    begin : stimulus
        int p, s, rv, pe;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_PATHS;
        cfg_wdata           <= '0;
        sym_if.valid        <= 1'b0;
        sym_if.symbol_index <= '0;
        sym_if.static_burst <= 1'b0;
        sym_if.squelched    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening under reset values (step size 4)
        send_symbol(SYM_W'(SYM_MAX), 1'b0, 1'b0);   // top bin, huge step
        send_symbol('0, 1'b1, 1'b1);                // puncture with both flags
        send_symbol(SYM_W'(512), 1'b0, 1'b0);
        send_step(STEP_TWO, 0, 1'b0, 1'b0);         // step edges of the tone set
        send_step(STEP_MAX, 0, 1'b0, 1'b0);
        send_step(STEP_MIN, 0, 1'b0, 1'b0);
        send_step(-1, 0, 1'b0, 1'b0);
        send_step(0, 0, 1'b0, 1'b0);                // out of range, both sides
        send_step(1, 0, 1'b0, 1'b0);
        send_step(STEP_MAX + 1, 0, 1'b0, 1'b0);
        send_step(STEP_MIN - 1, 0, 1'b0, 1'b0);
        send_step(5, 1, 1'b0, 1'b0);                // drift then opposite drift: resync
        send_step(7, -1, 1'b0, 1'b0);
        send_step(3, 2, 1'b0, 1'b0);                // drift at half a step
        send_step(9, -2, 1'b0, 1'b0);
        send_step(6, 1, 1'b0, 1'b1);                // squelch
        send_step(4, 0, 1'b1, 1'b0);                // static burst
        send_step(10, -1, 1'b1, 1'b1);
        send_step(12, 3, 1'b0, 1'b0);               // drift beyond half a step
        send_step(-8, 0, 1'b0, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < NUM_FIXED)
            begin
                p  = PHASE_SET[ph][0];
                s  = PHASE_SET[ph][1];
                rv = PHASE_SET[ph][2];
                pe = PHASE_SET[ph][3];
            end
            else
            begin
                p  = $urandom_range(0, 15);
                s  = $urandom_range(0, 7);
                rv = $urandom_range(0, 1);
                pe = $urandom_range(0, 1);
            end

            // drain before touching registers: every symbol yields one transaction
            sym_if.valid <= 1'b0;
            do @(posedge clk); while (pending_results != 0);

            // back-to-back register writes, write enable stays high
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PATHS;
            cfg_wdata <= CFG_DATA_W'(p);
            @(posedge clk);
            cfg_index <= CFG_SPACING;
            cfg_wdata <= CFG_DATA_W'(s);
            @(posedge clk);
            cfg_index <= CFG_REVERSE;
            cfg_wdata <= CFG_DATA_W'(rv);
            @(posedge clk);
            cfg_index <= CFG_PREAMBLE;
            cfg_wdata <= CFG_DATA_W'(pe);
            @(posedge clk);
            cfg_we <= 1'b0;

            stim_n       = (p == 0 ? 1 : p) * (s == 0 ? 1 : s);
            stim_reverse = rv[0];
            run_traffic(PHASE_LEN);
        end

        // drain, then allow one more symbol time for stray transactions
        sym_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: ifk_soft_symbol_demapper_top.f
rtl/ifk_pkg.sv
rtl/ifk_ifs.sv
rtl/ifk_div.sv
rtl/ifk_demap.sv
rtl/ifk_soft_symbol_demapper_top.sv
tb/ifk_demap_checker.sv
tb/tb_ifk_soft_symbol_demapper_top.sv
